// File: design/ttrr_pkg.sv
// shared constants, microcode table and helpers for the round-robin thread scheduler
`default_nettype none

package ttrr_pkg;

    localparam int SLOTS     = 16;
    localparam int ID_BITS   = 16;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int CNT_W     = $clog2(SLOTS + 1);
    localparam int ID_PORT_W = 16;
    localparam int SLOT_PORT_W = 4;
    localparam int CMP_W     = (ID_BITS > ID_PORT_W) ? ID_BITS : ID_PORT_W;
    localparam int PC_W      = 4;

    // request kinds
    localparam logic [2:0] REQ_CREATE   = 3'd0;
    localparam logic [2:0] REQ_END      = 3'd1;
    localparam logic [2:0] REQ_SLEEP    = 3'd2;
    localparam logic [2:0] REQ_WAKE     = 3'd3;
    localparam logic [2:0] REQ_SCHEDULE = 3'd4;

    // result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_NO_ID  = 2'd2;
    localparam logic [1:0] ST_NO_CUR = 2'd3;

    // microprogram entry points
    localparam logic [PC_W-1:0] A_CREATE = 4'd0;
    localparam logic [PC_W-1:0] A_END    = 4'd2;
    localparam logic [PC_W-1:0] A_SLEEP  = 4'd5;
    localparam logic [PC_W-1:0] A_WAKE   = 4'd8;
    localparam logic [PC_W-1:0] A_SCHED  = 4'd11;
    localparam logic [PC_W-1:0] A_PUB    = 4'd12;

    typedef enum logic [3:0] {
        U_NOP       = 4'd0,
        U_FIND_FREE = 4'd1,
        U_CREATE_WR = 4'd2,
        U_CHK_CUR   = 4'd3,
        U_END_CUR   = 4'd4,
        U_SLEEP_CUR = 4'd5,
        U_FIND_ID   = 4'd6,
        U_WAKE      = 4'd7,
        U_SCHED     = 4'd8
    } uop_t;

    typedef struct packed {
        uop_t            uop;
        logic            fail_jump;
        logic            go_jump;
        logic [PC_W-1:0] target;
        logic            publish;
    } uword_t;

    typedef struct packed {
        uop_t uop;
        logic start;
    } dp_ctrl_t;

    function automatic uword_t uw(input uop_t op, input logic fj, input logic gj,
                                  input logic [PC_W-1:0] tgt, input logic pub);
        uword_t w;
        w.uop       = op;
        w.fail_jump = fj;
        w.go_jump   = gj;
        w.target    = tgt;
        w.publish   = pub;
        return w;
    endfunction

    function automatic uword_t ucode_rom(input logic [PC_W-1:0] pc);
        uword_t w;
        case (pc)
            4'd0:    w = uw(U_FIND_FREE, 1'b1, 1'b0, A_PUB, 1'b0);
            4'd1:    w = uw(U_CREATE_WR, 1'b0, 1'b1, A_PUB, 1'b0);
            4'd2:    w = uw(U_CHK_CUR,   1'b1, 1'b0, A_PUB, 1'b0);
            4'd3:    w = uw(U_END_CUR,   1'b0, 1'b0, A_PUB, 1'b0);
            4'd4:    w = uw(U_SCHED,     1'b0, 1'b1, A_PUB, 1'b0);
            4'd5:    w = uw(U_CHK_CUR,   1'b1, 1'b0, A_PUB, 1'b0);
            4'd6:    w = uw(U_SLEEP_CUR, 1'b0, 1'b0, A_PUB, 1'b0);
            4'd7:    w = uw(U_SCHED,     1'b0, 1'b1, A_PUB, 1'b0);
            4'd8:    w = uw(U_FIND_ID,   1'b1, 1'b0, A_PUB, 1'b0);
            4'd9:    w = uw(U_WAKE,      1'b0, 1'b0, A_PUB, 1'b0);
            4'd10:   w = uw(U_SCHED,     1'b0, 1'b1, A_PUB, 1'b0);
            4'd11:   w = uw(U_SCHED,     1'b0, 1'b1, A_PUB, 1'b0);
            default: w = uw(U_NOP,       1'b0, 1'b0, A_PUB, 1'b1);
        endcase
        return w;
    endfunction

    function automatic logic [PC_W-1:0] dispatch(input logic [2:0] req);
        logic [PC_W-1:0] pc;
        case (req)
            REQ_CREATE:   pc = A_CREATE;
            REQ_END:      pc = A_END;
            REQ_SLEEP:    pc = A_SLEEP;
            REQ_WAKE:     pc = A_WAKE;
            REQ_SCHEDULE: pc = A_SCHED;
            default:      pc = A_PUB;
        endcase
        return pc;
    endfunction

    // index of the lowest set bit, zero when none
    function automatic logic [SLOT_W-1:0] lowest_set(input logic [SLOTS-1:0] v);
        logic [SLOT_W-1:0] idx;
        idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = SLOT_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

// File: design/ttrr_sequencer.sv
// microcode sequencer: step counter, control rom lookup and conditional jumps
`default_nettype none

module ttrr_sequencer (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    input  wire logic [2:0]         req_type,
    output logic                    s_tready,
    input  wire logic               out_free,
    input  wire logic               dp_fail,
    output ttrr_pkg::dp_ctrl_t      dp_ctrl,
    output logic                    load_out
);
    import ttrr_pkg::*;

    typedef enum logic [1:0] {
        SQ_IDLE = 2'b01,
        SQ_RUN  = 2'b10
    } seq_state_t;

    seq_state_t      state_reg, state_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    uword_t          uword;
    logic            accept;

    assign uword    = ucode_rom(pc_reg);
    assign s_tready = (state_reg == SQ_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next    = state_reg;
        pc_next       = pc_reg;
        load_out      = 1'b0;
        dp_ctrl.uop   = U_NOP;
        dp_ctrl.start = accept;
        case (state_reg)
            SQ_IDLE: begin
                if (accept) begin
                    pc_next    = dispatch(req_type);
                    state_next = SQ_RUN;
                end
            end
            SQ_RUN: begin
                if (uword.publish) begin
                    // hold here until the output register can take the beat
                    if (out_free) begin
                        load_out   = 1'b1;
                        state_next = SQ_IDLE;
                    end
                end else begin
                    dp_ctrl.uop = uword.uop;
                    if ((uword.fail_jump && dp_fail) || uword.go_jump) begin
                        pc_next = uword.target;
                    end else begin
                        pc_next = pc_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = SQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SQ_IDLE;
            pc_reg    <= A_PUB;
        end else begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
        end
    end

endmodule

`default_nettype wire

// File: design/ttrr_datapath.sv
// thread slot table, free/id/runnable searches and result registers
`default_nettype none

module ttrr_datapath (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire ttrr_pkg::dp_ctrl_t                 ctrl,
    input  wire logic                               start_waiting,
    input  wire logic [ttrr_pkg::ID_PORT_W-1:0]     target_id,
    output logic                                    dp_fail,
    output logic [1:0]                              status,
    output logic [ttrr_pkg::ID_PORT_W-1:0]          new_id,
    output logic                                    switched,
    output logic [ttrr_pkg::SLOT_PORT_W-1:0]        running_slot,
    output logic                                    running_is_boot
);
    import ttrr_pkg::*;

    logic [SLOTS-1:0]     present_reg;
    logic [SLOTS-1:0]     waiting_reg;
    logic [ID_BITS-1:0]   ident_reg [SLOTS];
    logic [ID_BITS-1:0]   next_ident_reg;
    logic [SLOT_W-1:0]    scan_reg;
    logic [SLOT_W-1:0]    cur_reg;
    logic                 on_boot_reg;
    logic [CNT_W-1:0]     live_reg;

    logic [1:0]           status_reg;
    logic [ID_BITS-1:0]   new_id_reg;
    logic                 switched_reg;
    logic [SLOT_W-1:0]    idx_reg;
    logic                 sw_reg;
    logic [ID_PORT_W-1:0] target_reg;

    logic                 have_cur;
    logic [SLOTS-1:0]     free_vec;
    logic                 free_any;
    logic [SLOT_W-1:0]    free_idx;
    logic [SLOTS-1:0]     match_vec;
    logic                 match_any;
    logic [SLOT_W-1:0]    match_idx;
    logic                 wake_ok;
    logic [SLOTS-1:0]     runnable;
    logic [SLOTS-1:0]     hi_vec;
    logic [SLOT_W-1:0]    start_pos;
    logic                 sched_hit;
    logic [SLOT_W-1:0]    sched_pick;
    logic                 live_any;

    assign have_cur = !on_boot_reg && present_reg[cur_reg];
    assign free_vec = ~present_reg;
    assign free_any = |free_vec;
    assign free_idx = lowest_set(free_vec);
    assign live_any = (live_reg != '0);

    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            match_vec[i] = (CMP_W'(ident_reg[i]) == CMP_W'(target_reg));
        end
    end
    assign match_any = |match_vec;
    assign match_idx = lowest_set(match_vec);
    assign wake_ok   = match_any && present_reg[match_idx];

    // circular scan: first runnable slot at or above start, else lowest runnable
    assign runnable  = present_reg & ~waiting_reg;
    assign start_pos = (scan_reg == SLOT_W'(SLOTS - 1)) ? '0 : scan_reg + 1'b1;
    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            hi_vec[i] = runnable[i] && (i >= int'(start_pos));
        end
    end
    assign sched_hit  = |runnable;
    assign sched_pick = (|hi_vec) ? lowest_set(hi_vec) : lowest_set(runnable);

    always_comb begin
        case (ctrl.uop)
            U_FIND_FREE: dp_fail = !free_any;
            U_CHK_CUR:   dp_fail = !have_cur;
            U_FIND_ID:   dp_fail = !wake_ok;
            default:     dp_fail = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            present_reg    <= '0;
            waiting_reg    <= '0;
            for (int i = 0; i < SLOTS; i++) begin
                ident_reg[i] <= '0;
            end
            next_ident_reg <= ID_BITS'(1);
            scan_reg       <= SLOT_W'(SLOTS - 1);
            cur_reg        <= '0;
            on_boot_reg    <= 1'b1;
            live_reg       <= '0;
        end else begin
            case (ctrl.uop)
                U_CREATE_WR: begin
                    present_reg[idx_reg] <= 1'b1;
                    waiting_reg[idx_reg] <= sw_reg;
                    ident_reg[idx_reg]   <= next_ident_reg;
                    live_reg             <= live_reg + 1'b1;
                    // id counter skips zero on wrap
                    next_ident_reg <= (next_ident_reg == '1) ? ID_BITS'(1)
                                                             : next_ident_reg + 1'b1;
                end
                U_END_CUR: begin
                    present_reg[cur_reg] <= 1'b0;
                    waiting_reg[cur_reg] <= 1'b0;
                    ident_reg[cur_reg]   <= '0;
                    if (live_any) begin
                        live_reg <= live_reg - 1'b1;
                    end
                end
                U_SLEEP_CUR: begin
                    waiting_reg[cur_reg] <= 1'b1;
                end
                U_WAKE: begin
                    waiting_reg[idx_reg] <= 1'b0;
                end
                U_SCHED: begin
                    if (live_any) begin
                        if (sched_hit) begin
                            scan_reg    <= sched_pick;
                            cur_reg     <= sched_pick;
                            on_boot_reg <= 1'b0;
                        end else begin
                            scan_reg <= start_pos;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.start) begin
            status_reg   <= ST_OK;
            new_id_reg   <= '0;
            switched_reg <= 1'b0;
            sw_reg       <= start_waiting;
            target_reg   <= target_id;
        end else begin
            case (ctrl.uop)
                U_FIND_FREE: begin
                    idx_reg <= free_idx;
                    if (!free_any) begin
                        status_reg <= ST_FULL;
                    end
                end
                U_CREATE_WR: begin
                    new_id_reg <= next_ident_reg;
                end
                U_CHK_CUR: begin
                    if (!have_cur) begin
                        status_reg <= ST_NO_CUR;
                    end
                end
                U_FIND_ID: begin
                    idx_reg <= match_idx;
                    if (!wake_ok) begin
                        status_reg <= ST_NO_ID;
                    end
                end
                U_SCHED: begin
                    switched_reg <= live_any && sched_hit;
                end
                default: begin
                end
            endcase
        end
    end

    assign status          = status_reg;
    assign new_id          = ID_PORT_W'(new_id_reg);
    assign switched        = switched_reg;
    assign running_slot    = SLOT_PORT_W'(cur_reg);
    assign running_is_boot = on_boot_reg;

`ifndef ASSERT_OFF
    a_live_count: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(present_reg) == int'(live_reg))
        else $error("live count differs from number of present slots");

    a_ident_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        next_ident_reg != '0)
        else $error("next id reached zero");

    a_create_free: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.uop == U_CREATE_WR |-> !present_reg[idx_reg])
        else $error("create writes an occupied slot");

    a_sched_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.uop == U_SCHED && live_any && sched_hit) |=>
            (!on_boot_reg && present_reg[cur_reg] && !waiting_reg[cur_reg]))
        else $error("switch landed on a slot that is not runnable");
`endif

endmodule

`default_nettype wire

// File: design/thread_table_round_robin_scheduler_core.sv
// top level of the round-robin thread scheduler: sequencer, slot datapath, output register
//
// usage: one request beat on the s_ channel gives exactly one result beat on the m_ channel.
// s_tuser carries the request kind (create, end current, sleep current, wake by id, schedule);
// s_tdata carries start_waiting and target_id. m_tdata returns status, new_id, switched,
// the running slot and whether the boot context is still current.
// a microcoded sequencer steps through a short program per request kind, one step per cycle,
// over a datapath that holds the thread table in flops; searches over the table are single-step
// priority scans. the last program step loads the result into the output register, so the
// wait for a result grows with the program: shortest for unknown kinds, then schedule, create,
// end/sleep/wake. s_tready is high whenever no request is in progress, so a new request is
// taken only once the one before has loaded its result; a result that the receiver has not taken
// does not block the next request, whose last step waits until the output register frees up.
// aresetn clears the table, sets the next id to one, puts the boot context in charge and
// drops any pending result.
`default_nettype none

module thread_table_round_robin_scheduler_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // start_waiting[0], target_id[16:1], zero pad
    input  wire logic [2:0]  s_tuser,   // req_type[2:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata    // status[1:0], new_id[17:2], switched[18],
                                        // running_slot[22:19], running_is_boot[23]
);
    import ttrr_pkg::*;

    dp_ctrl_t                dp_ctrl;
    logic                    dp_fail;
    logic                    load_out;
    logic                    out_free;
    logic [1:0]              status;
    logic [ID_PORT_W-1:0]    new_id;
    logic                    switched;
    logic [SLOT_PORT_W-1:0]  running_slot;
    logic                    running_is_boot;
    logic                    m_tvalid_reg;
    logic [23:0]             m_tdata_reg;

    assign out_free = !m_tvalid_reg || m_tready;

    ttrr_sequencer u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .req_type (s_tuser),
        .s_tready (s_tready),
        .out_free (out_free),
        .dp_fail  (dp_fail),
        .dp_ctrl  (dp_ctrl),
        .load_out (load_out)
    );

    ttrr_datapath u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .ctrl            (dp_ctrl),
        .start_waiting   (s_tdata[0]),
        .target_id       (s_tdata[16:1]),
        .dp_fail         (dp_fail),
        .status          (status),
        .new_id          (new_id),
        .switched        (switched),
        .running_slot    (running_slot),
        .running_is_boot (running_is_boot)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_tdata_reg <= {running_is_boot, running_slot, switched, new_id, status};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

// File: verif/testbench.sv
// self-checking testbench for the round-robin thread table scheduler core
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ttrr_pkg::*;

    localparam logic [2:0] REQ_UNKNOWN_FIRST = 3'd5;
    localparam logic [2:0] REQ_UNKNOWN_LAST  = 3'd7;
    localparam int         WATCHDOG_LIMIT    = 1000;
    localparam int         MAX_PRINTED       = 40;

    // same layout as m_tdata, lowest field last
    typedef struct packed {
        logic                   boot;
        logic [SLOT_PORT_W-1:0] slot;
        logic                   switched;
        logic [ID_PORT_W-1:0]   new_id;
        logic [1:0]             status;
    } reply_t;

    class thread_table_model;
        bit                 present [SLOTS];
        bit                 waiting [SLOTS];
        logic [ID_BITS-1:0] ident [SLOTS];
        logic [ID_BITS-1:0] next_ident;
        int                 scan_pos;
        int                 cur_slot;
        bit                 on_boot;
        int                 live_count;
        reply_t             pending_replies[$];
        int                 mismatch_count;
        int                 requests_seen;
        int                 replies_seen;
        int                 switch_count;
        int                 full_count;
        int                 no_id_count;
        int                 no_cur_count;
        int                 id_wraps;

        function new();
            for (int i = 0; i < SLOTS; i++) begin
                present[i] = 1'b0;
                waiting[i] = 1'b0;
                ident[i]   = '0;
            end
            next_ident     = 1;
            scan_pos       = SLOTS - 1;
            cur_slot       = 0;
            on_boot        = 1'b1;
            live_count     = 0;
            mismatch_count = 0;
            requests_seen  = 0;
            replies_seen   = 0;
            switch_count   = 0;
            full_count     = 0;
            no_id_count    = 0;
            no_cur_count   = 0;
            id_wraps       = 0;
        endfunction

        function bit has_current();
            return !on_boot && present[cur_slot];
        endfunction

        function logic [ID_PORT_W-1:0] pick_live_id();
            int live_idx[$];
            for (int i = 0; i < SLOTS; i++) begin
                if (present[i]) begin
                    live_idx.push_back(i);
                end
            end
            if (live_idx.size() == 0) begin
                return ID_PORT_W'($urandom_range(65535));
            end
            return ID_PORT_W'(ident[live_idx[$urandom_range(live_idx.size() - 1)]]);
        endfunction

        // circular scan starting just past the last scan position
        function bit switch_to_next();
            int first;
            int s;
            if (live_count == 0) begin
                return 1'b0;
            end
            first = (scan_pos + 1) % SLOTS;
            for (int k = 0; k < SLOTS; k++) begin
                s = (first + k) % SLOTS;
                if (present[s] && !waiting[s]) begin
                    scan_pos = s;
                    cur_slot = s;
                    on_boot  = 1'b0;
                    return 1'b1;
                end
            end
            scan_pos = first;
            return 1'b0;
        endfunction

        function void note_request(logic [2:0] req, logic start_wait, logic [ID_PORT_W-1:0] tid);
            reply_t r;
            bit     hit;
            int     idx;
            r   = '0;
            hit = 1'b0;
            idx = 0;
            case (req)
                REQ_CREATE: begin
                    for (int i = 0; i < SLOTS && !hit; i++) begin
                        if (!present[i]) begin
                            hit = 1'b1;
                            idx = i;
                        end
                    end
                    if (!hit) begin
                        r.status = ST_FULL;
                    end else begin
                        r.new_id     = ID_PORT_W'(next_ident);
                        ident[idx]   = next_ident;
                        present[idx] = 1'b1;
                        waiting[idx] = start_wait;
                        live_count++;
                        next_ident++;
                        // zero is never handed out
                        if (next_ident == 0) begin
                            next_ident = 1;
                            id_wraps++;
                        end
                    end
                end
                REQ_END: begin
                    if (!has_current()) begin
                        r.status = ST_NO_CUR;
                    end else begin
                        present[cur_slot] = 1'b0;
                        waiting[cur_slot] = 1'b0;
                        ident[cur_slot]   = '0;
                        if (live_count > 0) begin
                            live_count--;
                        end
                        r.switched = switch_to_next();
                    end
                end
                REQ_SLEEP: begin
                    if (!has_current()) begin
                        r.status = ST_NO_CUR;
                    end else begin
                        waiting[cur_slot] = 1'b1;
                        r.switched = switch_to_next();
                    end
                end
                REQ_WAKE: begin
                    for (int i = 0; i < SLOTS && !hit; i++) begin
                        if (CMP_W'(ident[i]) == CMP_W'(tid)) begin
                            hit = 1'b1;
                            idx = i;
                        end
                    end
                    if (!hit || !present[idx]) begin
                        r.status = ST_NO_ID;
                    end else begin
                        waiting[idx] = 1'b0;
                        r.switched = switch_to_next();
                    end
                end
                REQ_SCHEDULE: begin
                    r.switched = switch_to_next();
                end
                default: begin
                end
            endcase
            r.slot = SLOT_PORT_W'(cur_slot);
            r.boot = on_boot;
            requests_seen++;
            if (r.switched) switch_count++;
            if (r.status == ST_FULL) full_count++;
            if (r.status == ST_NO_ID) no_id_count++;
            if (r.status == ST_NO_CUR) no_cur_count++;
            pending_replies.push_back(r);
        endfunction

        task report_mismatch(string what, int unsigned got, int unsigned want);
            mismatch_count++;
            if (mismatch_count <= MAX_PRINTED) begin
                $display("[%0t] reply %0d: %s is 0x%0h, expected 0x%0h",
                         $realtime, replies_seen, what, got, want);
            end
        endtask

        task check_reply(logic [23:0] data);
            reply_t got;
            reply_t want;
            got = reply_t'(data);
            replies_seen++;
            if (pending_replies.size() == 0) begin
                report_mismatch("unexpected beat, data", data, 0);
                return;
            end
            want = pending_replies.pop_front();
            if (got.status != want.status)
                report_mismatch("status", got.status, want.status);
            if (got.new_id != want.new_id)
                report_mismatch("new_id", got.new_id, want.new_id);
            if (got.switched != want.switched)
                report_mismatch("switched", got.switched, want.switched);
            if (got.slot != want.slot)
                report_mismatch("running_slot", got.slot, want.slot);
            if (got.boot != want.boot)
                report_mismatch("running_is_boot", got.boot, want.boot);
        endtask
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;

    thread_table_model model;
    bit                idling_on;
    int                send_gap_pct;
    int                recv_stall_pct;
    int                stall_left;
    int                quiet_cycles;

    thread_table_round_robin_scheduler_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    task automatic send_request(logic [2:0] req, logic start_wait, logic [ID_PORT_W-1:0] tid);
        @(negedge aclk);
        if (idling_on && $urandom_range(99) < send_gap_pct) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = req;
        s_tdata  = {7'd0, tid, start_wait};
        do @(posedge aclk); while (!s_tready);
        model.note_request(req, start_wait, tid);
    endtask

    task automatic run_directed();
        send_request(REQ_SCHEDULE, 1'b0, 16'h0000);   // empty table
        send_request(REQ_END, 1'b0, 16'h0000);        // boot context runs
        send_request(REQ_SLEEP, 1'b1, 16'hffff);
        send_request(REQ_WAKE, 1'b0, 16'h0000);
        send_request(REQ_WAKE, 1'b1, 16'hffff);
        send_request(REQ_UNKNOWN_FIRST, 1'b1, 16'hffff);
        send_request(REQ_UNKNOWN_LAST, 1'b0, 16'h0000);
        send_request(REQ_CREATE, 1'b1, 16'hffff);     // starts waiting
        send_request(REQ_SCHEDULE, 1'b0, 16'h0000);   // nothing runnable yet
        send_request(REQ_CREATE, 1'b0, 16'h0000);
        send_request(REQ_SCHEDULE, 1'b0, 16'h0000);
        send_request(REQ_SCHEDULE, 1'b0, 16'h0000);   // same slot again
        send_request(REQ_END, 1'b0, 16'h0000);        // leaves a stale current slot
        send_request(REQ_END, 1'b0, 16'h0000);
        send_request(REQ_SLEEP, 1'b0, 16'h0000);
        send_request(REQ_WAKE, 1'b0, 16'h0001);
        send_request(REQ_CREATE, 1'b0, 16'h5555);
        send_request(REQ_CREATE, 1'b1, 16'haaaa);
        send_request(REQ_SLEEP, 1'b0, 16'h0000);
        send_request(REQ_WAKE, 1'b0, 16'h0002);       // id already freed
        send_request(REQ_WAKE, 1'b0, 16'h0004);
        send_request(REQ_WAKE, 1'b0, 16'h0001);
        send_request(REQ_END, 1'b0, 16'h0000);
        send_request(REQ_SCHEDULE, 1'b1, 16'hffff);
    endtask

    task automatic run_random(int n_items, bit vary_idling);
        int                   counted;
        int                   pick;
        logic [2:0]           req;
        logic                 start_wait;
        logic [ID_PORT_W-1:0] tid;
        counted = 0;
        while (counted < n_items) begin
            if (vary_idling && $urandom_range(149) == 0) begin
                case ($urandom_range(2))
                    0: send_gap_pct = 0;
                    1: send_gap_pct = 10;
                    default: send_gap_pct = 35;
                endcase
                case ($urandom_range(2))
                    0: recv_stall_pct = 0;
                    1: recv_stall_pct = 10;
                    default: recv_stall_pct = 35;
                endcase
            end
            pick       = $urandom_range(99);
            start_wait = 1'($urandom_range(1));
            tid        = ID_PORT_W'($urandom_range(65535));
            if (pick < 24) begin
                req = REQ_CREATE;
            end else if (pick < 38) begin
                req = REQ_END;
            end else if (pick < 52) begin
                req = REQ_SLEEP;
            end else if (pick < 78) begin
                req = REQ_WAKE;
                // mostly ids of live threads, some misses
                if ($urandom_range(9) < 7) begin
                    tid = model.pick_live_id();
                end else if ($urandom_range(3) == 0) begin
                    tid = '0;
                end
            end else if (pick < 94) begin
                req = REQ_SCHEDULE;
            end else begin
                req = 3'($urandom_range(REQ_UNKNOWN_FIRST, REQ_UNKNOWN_LAST));
            end
            send_request(req, start_wait, tid);
            if (req <= REQ_SCHEDULE) begin
                counted++;
            end
        end
    endtask

    // result side back-pressure in bursts
    initial begin
        m_tready   = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (aresetn) begin
                if (idling_on && stall_left == 0 && $urandom_range(99) < recv_stall_pct) begin
                    stall_left = $urandom_range(1, 15);
                end
                if (stall_left > 0) begin
                    m_tready = 1'b0;
                    stall_left--;
                end else begin
                    m_tready = 1'b1;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            model.check_reply(m_tdata);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat on either channel for %0d cycles, %0d replies outstanding",
                     quiet_cycles, model.pending_replies.size());
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = '0;
        quiet_cycles   = 0;
        idling_on      = 1'b1;
        send_gap_pct   = 20;
        recv_stall_pct = 20;
        model          = new();
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        run_directed();
        run_random(1300, 1'b1);
        idling_on = 1'b0;
        run_random(250, 1'b0);

        @(negedge aclk);
        s_tvalid = 1'b0;
        while (model.pending_replies.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("covered %0d requests and %0d replies: %0d switches, %0d id wraps",
                 model.requests_seen, model.replies_seen, model.switch_count, model.id_wraps);
        $display("error answers seen: %0d table full, %0d unknown id, %0d no current thread",
                 model.full_count, model.no_id_count, model.no_cur_count);
        if (model.mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches", model.mismatch_count);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
design/ttrr_pkg.sv
design/ttrr_sequencer.sv
design/ttrr_datapath.sv
design/thread_table_round_robin_scheduler_core.sv
verif/testbench.sv
